>>> hw/rtl/counting_semaphore_wait_queue_core_macros.svh
// Assertion macros shared by the counting semaphore wait queue RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only outside reset
`define CSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define CSQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSQ_ASSERT(lbl, prop, msg)
`define CSQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/csq_pkg.sv
// Package for the counting semaphore wait queue: shared types and codes.
// No dependencies.
`default_nettype none

package csq_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WAIT  = 2'd1,
        ST_CHECK = 2'd2
    } csq_state_t;

    // Result status codes
    typedef enum logic [1:0] {
        RS_ACK    = 2'd0,
        RS_GRANT  = 2'd1,
        RS_REJECT = 2'd2
    } reply_status_t;

    // One queued waiter
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  amount;
    } waiter_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take the input item
        logic grant;      // grant the queue head
        logic emit_last;  // flush pending result as final
    } csq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic queue_empty;
        logic count_covers;
    } csq_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/csq_ctrl.sv
// Controller state machine for the counting semaphore wait queue.
// Depends on csq_pkg.
`default_nettype none

module csq_ctrl
    import csq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire csq_stat_t stat,
    output csq_cmd_t       cmd
);

    csq_state_t state_reg;
    csq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            // head entry read is in flight
            ST_WAIT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!stat.queue_empty && stat.count_covers)
                begin
                    cmd.grant  = 1'b1;
                    state_next = ST_WAIT;
                end
                else
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/csq_datapath.sv
// Datapath: semaphore count, waiter ring memory, pending and output registers.
// Depends on csq_pkg and counting_semaphore_wait_queue_core_macros.svh.
`default_nettype none
`include "counting_semaphore_wait_queue_core_macros.svh"

module csq_datapath
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire csq_cmd_t           cmd,
    output csq_stat_t               stat,
    input  wire logic [15:0]        client_id,
    input  wire logic signed [8:0]  request_amount,
    output logic                    reply_valid,
    output logic [15:0]             reply_id,
    output logic [1:0]              reply_status,
    output logic                    last_reply
);

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

    // Waiter ring, undefined until written
    waiter_t mem [QUEUE_DEPTH];
    waiter_t rd_data_reg;

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [ADDR_W-1:0]      head_reg;
    logic [ADDR_W-1:0]      tail_reg;
    logic [FILL_W-1:0]      fill_reg;

    logic                   pend_valid_reg;
    logic [15:0]            pend_id_reg;
    reply_status_t          pend_status_reg;

    logic                   out_valid_reg;
    logic [15:0]            out_id_reg;
    reply_status_t          out_status_reg;
    logic                   out_last_reg;

    logic                   is_wait;
    logic                   queue_full;
    logic [8:0]             neg_amount;
    logic [7:0]             wait_mag;
    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] sat_count;
    logic [COUNT_WIDTH-1:0] head_need;
    waiter_t                wr_entry;

    // Input decode: saturated signal sum and wait magnitude
    always_comb
    begin
        is_wait    = request_amount[8];
        queue_full = (fill_reg == FULL_FILL);
        neg_amount = ~request_amount + 9'd1;
        wait_mag   = neg_amount[8] ? 8'hFF : neg_amount[7:0];
        sum        = {1'b0, count_reg} + (COUNT_WIDTH + 1)'(request_amount[7:0]);
        sat_count  = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        head_need  = COUNT_WIDTH'(rd_data_reg.amount);
        wr_entry.id     = client_id;
        wr_entry.amount = wait_mag;
    end

    // Status to controller
    always_comb
    begin
        stat.queue_empty  = (fill_reg == '0);
        stat.count_covers = (count_reg >= head_need);
    end

    // Ring memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (cmd.load && is_wait && !queue_full)
        begin
            mem[tail_reg] <= wr_entry;
        end
        rd_data_reg <= mem[head_reg];
    end

    // Count and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else if (cmd.load)
        begin
            if (!is_wait)
            begin
                count_reg <= sat_count;
            end
            else if (!queue_full)
            begin
                tail_reg <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
        end
        else if (cmd.grant)
        begin
            count_reg <= count_reg - head_need;
            head_reg  <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            fill_reg  <= fill_reg - 1'b1;
        end
    end

    // Pending result: held back until we know whether another follows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            pend_valid_reg <= !is_wait || queue_full;
        end
        else if (cmd.grant)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.emit_last)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pend_id_reg     <= client_id;
            pend_status_reg <= is_wait ? RS_REJECT : RS_ACK;
        end
        else if (cmd.grant)
        begin
            pend_id_reg     <= rd_data_reg.id;
            pend_status_reg <= RS_GRANT;
        end
    end

    // Output strobe register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= (cmd.grant || cmd.emit_last) && pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grant || cmd.emit_last)
        begin
            out_id_reg     <= pend_id_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= cmd.emit_last;
        end
    end

    assign reply_valid  = out_valid_reg;
    assign reply_id     = out_id_reg;
    assign reply_status = out_status_reg;
    assign last_reply   = out_last_reg;

    `CSQ_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FULL_FILL, "queue fill beyond depth")
    `CSQ_ASSERT(a_grant_legal, cmd.grant |-> fill_reg != '0 && count_reg >= head_need, "bad grant")
    `CSQ_ASSERT(a_ring_empty, (fill_reg == '0) |-> (head_reg == tail_reg), "empty ring pointers differ")
    `CSQ_ASSERT(a_last_flush, cmd.emit_last |=> !pend_valid_reg, "pending result survived flush")

endmodule

`default_nettype wire

>>> hw/rtl/counting_semaphore_wait_queue_core.sv
// Top level of the counting semaphore wait queue.
// Depends on csq_pkg, csq_ctrl and csq_datapath.
//
// Usage:
//   Command channel: an item (client_id, request_amount) is taken at a clock
//   edge with start high and busy low. A zero or positive amount adds to the
//   count (saturating) and is acknowledged; a negative amount is queued as a
//   waiter, or rejected when the queue is full.
//   Result channel: reply_valid strobes for one cycle per result with
//   reply_id, reply_status and last_reply. Waiters are granted strictly in
//   arrival order from the queue head while the count covers them.
//   Sequence: after the accept edge busy stays high through states WAIT and
//   CHECK, and once more through WAIT and CHECK for each grant, so no new
//   item is taken until the current one is done; the WAIT before each check
//   covers the registered read of the waiter memory at the head pointer.
//   Each result is registered into the output strobe register as CHECK
//   grants or ends the item; the final one has last_reply set. An item
//   may give no result.
//   Reset: count, pointers and fill clear at once; waiter memory is not
//   cleared. The receiver cannot stall; results are never held back.
`default_nettype none

module counting_semaphore_wait_queue_core
    import csq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        client_id,
    input  wire logic signed [8:0]  request_amount,
    output logic                    reply_valid,
    output logic [15:0]             reply_id,
    output logic [1:0]              reply_status,
    output logic                    last_reply
);

    csq_cmd_t  cmd;
    csq_stat_t stat;

    // Sequencer
    csq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Count, queue and result registers
    csq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .client_id      (client_id),
        .request_amount (request_amount),
        .reply_valid    (reply_valid),
        .reply_id       (reply_id),
        .reply_status   (reply_status),
        .last_reply     (last_reply)
    );

endmodule

`default_nettype wire
